// ----- src/pld_pkg.sv -----
// Shared constants and request codes for the point-to-polyline distance unit.
package pld_pkg;

   localparam int KIND_BITS = 2;
   localparam int DIST_BITS = 25;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_QUERY  = 2'd2
   } kind_type;

endpackage

// ----- src/pld_req_if.sv -----
// Request channel: kind, point coordinates and prior distance.
interface pld_req_if #(
   parameter int CoordBits = 24
);
   logic                          valid;
   logic                          ready;
   logic [pld_pkg::KIND_BITS-1:0] kind;
   logic signed [CoordBits-1:0]   point_x;
   logic signed [CoordBits-1:0]   point_y;
   logic [pld_pkg::DIST_BITS-1:0] prior_distance;

   modport source (output valid, kind, point_x, point_y, prior_distance, input ready);
   modport sink (input valid, kind, point_x, point_y, prior_distance, output ready);
endinterface

// ----- src/pld_rsp_if.sv -----
// Response channel: distance and truncation flag.
interface pld_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pld_pkg::DIST_BITS-1:0] distance;
   logic                          contour_truncated;

   modport source (output valid, distance, contour_truncated, input ready);
   modport sink (input valid, distance, contour_truncated, output ready);
endinterface

// ----- src/pld_vertex_mem.sv -----
// Vertex memory: one write port, one read port with registered read data.
module pld_vertex_mem #(
   parameter int Depth    = 1024,
   parameter int DataBits = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [DataBits-1:0]      wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [DataBits-1:0]      rd_data
);
   logic [DataBits-1:0] mem_ff [Depth];
   logic [DataBits-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- src/pld_seg_dist.sv -----
// Squared distance from a point to one segment, with a bit-serial divider.
module pld_seg_dist #(
   parameter int CoordBits = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [CoordBits-1:0]          ax,
   input  logic signed [CoordBits-1:0]          ay,
   input  logic signed [CoordBits-1:0]          bx,
   input  logic signed [CoordBits-1:0]          by,
   input  logic signed [CoordBits-1:0]          qx,
   input  logic signed [CoordBits-1:0]          qy,
   output logic                                 done,
   output logic [2*(CoordBits+1):0]             d2
);
   localparam int D  = CoordBits + 1;
   localparam int W  = 2 * D + 1;
   localparam int IW = $clog2(W);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_SUM, S_CHK, S_DIV, S_FIN
   } state_type;

   state_type state_ff;
   logic signed [D-1:0]   dx_ff, dy_ff, px_ff, py_ff, ex_ff, ey_ff;
   logic signed [2*D-1:0] pxx_ff, pyy_ff, dxx_ff, dyy_ff, pdx_ff, pdy_ff, exx_ff, eyy_ff;
   logic signed [W-1:0]   pa2_ff, l2_ff, pb2_ff, dot_ff;
   logic [W-1:0]          r_ff, q_ff, d2_ff;
   logic [IW-1:0]         bit_ff;
   logic                  done_ff;

   logic [W:0]   t0_in, t1_in, t2_in;
   logic [W:0]   l2_ext;
   logic [1:0]   k_in;
   logic         ge0, ge1;

   // One quotient step: shift remainder, add dot on a set bit, reduce twice.
   always_comb begin
      l2_ext = (W+1)'(unsigned'(l2_ff));
      t0_in  = {r_ff, 1'b0} + (dot_ff[bit_ff] ? (W+1)'(unsigned'(dot_ff)) : '0);
      ge0    = (t0_in >= l2_ext);
      t1_in  = ge0 ? t0_in - l2_ext : t0_in;
      ge1    = (t1_in >= l2_ext);
      t2_in  = ge1 ? t1_in - l2_ext : t1_in;
      k_in   = 2'(ge0) + 2'(ge1);
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  dx_ff    <= D'(bx) - D'(ax);
                  dy_ff    <= D'(by) - D'(ay);
                  px_ff    <= D'(qx) - D'(ax);
                  py_ff    <= D'(qy) - D'(ay);
                  ex_ff    <= D'(qx) - D'(bx);
                  ey_ff    <= D'(qy) - D'(by);
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               pxx_ff   <= px_ff * px_ff;
               pyy_ff   <= py_ff * py_ff;
               dxx_ff   <= dx_ff * dx_ff;
               dyy_ff   <= dy_ff * dy_ff;
               pdx_ff   <= px_ff * dx_ff;
               pdy_ff   <= py_ff * dy_ff;
               exx_ff   <= ex_ff * ex_ff;
               eyy_ff   <= ey_ff * ey_ff;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               pa2_ff   <= W'(pxx_ff) + W'(pyy_ff);
               l2_ff    <= W'(dxx_ff) + W'(dyy_ff);
               pb2_ff   <= W'(exx_ff) + W'(eyy_ff);
               dot_ff   <= W'(pdx_ff) + W'(pdy_ff);
               state_ff <= S_CHK;
            end
            S_CHK: begin
               if (l2_ff == '0 || dot_ff < 0) begin
                  d2_ff    <= unsigned'(pa2_ff);
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end else if (dot_ff > l2_ff) begin
                  d2_ff    <= unsigned'(pb2_ff);
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  r_ff     <= '0;
                  q_ff     <= '0;
                  bit_ff   <= IW'(W - 1);
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               r_ff <= t2_in[W-1:0];
               q_ff <= {q_ff[W-2:0], 1'b0} + W'(k_in);
               if (bit_ff == '0) begin
                  state_ff <= S_FIN;
               end else begin
                  bit_ff <= bit_ff - 1'b1;
               end
            end
            S_FIN: begin
               // Round the dot-squared quotient up, then subtract from |P-A|^2.
               d2_ff    <= unsigned'(pa2_ff) - q_ff - W'(r_ff != '0);
               done_ff  <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign d2   = d2_ff;
endmodule

// ----- src/pld_isqrt.sv -----
// Integer square root, two radicand bits per cycle.
module pld_isqrt #(
   parameter int ValueBits = 51
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ValueBits-1:0]           value,
   output logic                           done,
   output logic [(ValueBits+1)/2-1:0]     root
);
   localparam int RW = (ValueBits + 1) / 2;
   localparam int CW = (RW > 1) ? $clog2(RW) : 1;

   typedef enum logic {S_IDLE, S_RUN} state_type;

   state_type       state_ff;
   logic [2*RW-1:0] val_ff;
   logic [RW+1:0]   rem_ff;
   logic [RW-1:0]   root_ff;
   logic [CW-1:0]   cnt_ff;
   logic            done_ff;

   logic [RW+3:0]   rem_sh, trial;
   logic            take;

   always_comb begin
      rem_sh = {rem_ff, val_ff[2*RW-1 -: 2]};
      trial  = (RW+4)'({root_ff, 2'b01});
      take   = (rem_sh >= trial);
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  val_ff   <= (2*RW)'(value);
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  cnt_ff   <= CW'(RW - 1);
                  state_ff <= S_RUN;
               end
            end
            S_RUN: begin
               val_ff  <= {val_ff[2*RW-3:0], 2'b00};
               rem_ff  <= take ? (RW+2)'(rem_sh - trial) : rem_sh[RW+1:0];
               root_ff <= {root_ff[RW-2:0], take};
               if (cnt_ff == '0) begin
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

// ----- src/point_to_polyline_distance_unit.sv -----
// Top level of the point-to-polyline distance unit.
//
// Holds one polyline contour in a vertex memory and answers point queries.
// Requests arrive on req (valid/ready): kind CLEAR empties the contour,
// APPEND stores a vertex (dropped and flagged once the memory is full),
// QUERY returns one response on rsp with min(prior_distance, distance from
// the point to the nearest contour segment). CLEAR and APPEND give no response.
// One request is in work at a time. A query walks the segments in order:
// each segment costs one memory read and one pass of the segment unit,
// which runs the bit-serial divider only when the nearest point lies inside
// the segment, not when it is a vertex. The square root of the smallest
// squared distance follows the walk. A query on fewer than two vertices
// skips the walk and answers with the prior distance.
// Responses sit in an output register; a new request is taken while it
// waits, but a finished query holds until the register frees up.
// Synchronous reset empties the contour and clears the truncation flag;
// the vertex memory itself is not cleared and needs no clearing pass.
module point_to_polyline_distance_unit #(
   parameter int MAX_VERTICES = 1024,
   parameter int COORD_BITS   = 24
) (
   input  logic  clock,
   input  logic  reset,
   pld_req_if.sink   req,
   pld_rsp_if.source rsp
);
   localparam int AW   = $clog2(MAX_VERTICES);
   localparam int NW   = $clog2(MAX_VERTICES + 1);
   localparam int W    = 2 * (COORD_BITS + 1) + 1;
   localparam int RW   = (W + 1) / 2;
   localparam int DB   = pld_pkg::DIST_BITS;
   localparam int MW   = (RW > DB) ? RW : DB;

   typedef enum logic [2:0] {
      ST_IDLE, ST_RD_FIRST, ST_RD_NEXT, ST_SEG, ST_ROOT, ST_FINISH
   } state_type;

   state_type state_ff;
   logic [NW-1:0]                 count_ff;
   logic                          trunc_ff;
   logic [NW-1:0]                 idx_ff;
   logic signed [COORD_BITS-1:0]  qx_ff, qy_ff, prev_x_ff, prev_y_ff;
   logic [DB-1:0]                 prior_ff, result_ff;
   logic [W-1:0]                  best_ff;
   logic                          first_ff;
   logic                          rsp_valid_ff;
   logic [DB-1:0]                 rsp_dist_ff;
   logic                          rsp_trunc_ff;

   logic                          accept;
   logic                          mem_wr_en, mem_rd_en;
   logic [AW-1:0]                 mem_rd_addr;
   logic [2*COORD_BITS-1:0]       mem_rd_data;
   logic signed [COORD_BITS-1:0]  cur_x, cur_y;
   logic                          seg_start, seg_done;
   logic [W-1:0]                  seg_d2, best_in;
   logic                          root_start, root_done;
   logic [RW-1:0]                 root;
   logic [NW-1:0]                 idx_next;
   logic                          more_segs;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign cur_x     = mem_rd_data[2*COORD_BITS-1:COORD_BITS];
   assign cur_y     = mem_rd_data[COORD_BITS-1:0];
   assign idx_next  = idx_ff + 1'b1;
   assign more_segs = (idx_next < count_ff);
   assign best_in   = (first_ff || seg_d2 < best_ff) ? seg_d2 : best_ff;

   // Memory access and unit launches follow the sequencer state.
   always_comb begin
      mem_wr_en   = accept && req.kind == pld_pkg::KIND_APPEND
                    && count_ff < NW'(MAX_VERTICES);
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      seg_start   = 1'b0;
      root_start  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            mem_rd_en = accept && req.kind == pld_pkg::KIND_QUERY;
         end
         ST_RD_FIRST: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = idx_ff[AW-1:0];
         end
         ST_RD_NEXT: begin
            seg_start = 1'b1;
         end
         ST_SEG: begin
            if (seg_done) begin
               mem_rd_en   = more_segs;
               mem_rd_addr = idx_next[AW-1:0];
               root_start  = !more_segs;
            end
         end
         default: ;
      endcase
   end

   pld_vertex_mem #(
      .Depth    (MAX_VERTICES),
      .DataBits (2 * COORD_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({req.point_x, req.point_y}),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   pld_seg_dist #(
      .CoordBits (COORD_BITS)
   ) u_seg (
      .clock (clock),
      .reset (reset),
      .start (seg_start),
      .ax    (prev_x_ff),
      .ay    (prev_y_ff),
      .bx    (cur_x),
      .by    (cur_y),
      .qx    (qx_ff),
      .qy    (qy_ff),
      .done  (seg_done),
      .d2    (seg_d2)
   );

   pld_isqrt #(
      .ValueBits (W)
   ) u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .value (best_in),
      .done  (root_done),
      .root  (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         trunc_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the response once the receiver takes it, unless a new one loads.
         if (rsp_valid_ff && rsp.ready && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (req.kind)
                     pld_pkg::KIND_CLEAR: begin
                        count_ff <= '0;
                        trunc_ff <= 1'b0;
                     end
                     pld_pkg::KIND_APPEND: begin
                        if (count_ff < NW'(MAX_VERTICES)) begin
                           count_ff <= count_ff + 1'b1;
                        end else begin
                           trunc_ff <= 1'b1;
                        end
                     end
                     pld_pkg::KIND_QUERY: begin
                        qx_ff     <= req.point_x;
                        qy_ff     <= req.point_y;
                        prior_ff  <= req.prior_distance;
                        result_ff <= req.prior_distance;
                        idx_ff    <= NW'(1);
                        first_ff  <= 1'b1;
                        state_ff  <= (count_ff >= NW'(2)) ? ST_RD_FIRST : ST_FINISH;
                     end
                     default: ;
                  endcase
               end
            end
            ST_RD_FIRST: begin
               prev_x_ff <= cur_x;
               prev_y_ff <= cur_y;
               state_ff  <= ST_RD_NEXT;
            end
            ST_RD_NEXT: begin
               state_ff <= ST_SEG;
            end
            ST_SEG: begin
               if (seg_done) begin
                  // Advance: the end vertex becomes the next start vertex.
                  best_ff   <= best_in;
                  first_ff  <= 1'b0;
                  prev_x_ff <= cur_x;
                  prev_y_ff <= cur_y;
                  if (more_segs) begin
                     idx_ff   <= idx_next;
                     state_ff <= ST_RD_NEXT;
                  end else begin
                     state_ff <= ST_ROOT;
                  end
               end
            end
            ST_ROOT: begin
               if (root_done) begin
                  if (MW'(root) < MW'(prior_ff)) begin
                     result_ff <= DB'(root);
                  end
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               // Hold the answer until the output register is free.
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_dist_ff  <= result_ff;
                  rsp_trunc_ff <= trunc_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.distance          = rsp_dist_ff;
   assign rsp.contour_truncated = rsp_trunc_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(MAX_VERTICES))
      else $error("vertex count beyond capacity");

   a_full_flags: assert property (@(posedge clock) disable iff (reset)
      (accept && req.kind == pld_pkg::KIND_APPEND && count_ff == NW'(MAX_VERTICES))
      |=> trunc_ff)
      else $error("dropped append not flagged");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finish");
`endif
endmodule

// ----- bench/point_to_polyline_distance_unit_test.sv -----
// Self-checking testbench for the point-to-polyline distance unit.
module point_to_polyline_distance_unit_test;

   localparam int MAX_VERTICES = 1024;
   localparam int COORD_BITS   = 24;
   localparam logic [pld_pkg::KIND_BITS-1:0] KIND_UNUSED = 2'd3;
   localparam int DIST_MAX = (1 << pld_pkg::DIST_BITS) - 1;
   localparam int COORD_MIN = -(1 << (COORD_BITS - 1));
   localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;

   typedef struct {
      logic [pld_pkg::KIND_BITS-1:0] kind;
      logic signed [COORD_BITS-1:0]  x;
      logic signed [COORD_BITS-1:0]  y;
      logic [pld_pkg::DIST_BITS-1:0] prior;
   } request_type;

   typedef struct {
      logic [pld_pkg::DIST_BITS-1:0] distance;
      logic                          truncated;
   } answer_type;

   logic clock;
   logic reset;

   pld_req_if #(.CoordBits(COORD_BITS)) req ();
   pld_rsp_if rsp ();

   point_to_polyline_distance_unit #(
      .MAX_VERTICES(MAX_VERTICES),
      .COORD_BITS  (COORD_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req  (req),
      .rsp  (rsp)
   );

   request_type pending_requests[$];
   answer_type  expected_answers[$];
   request_type current_request;
   bit          request_fired;
   int          send_idle_pct;
   int          stall_pct;
   int          mismatches;

   // Shadow copy of the contour, updated as each request is accepted.
   longint contour_x[MAX_VERTICES];
   longint contour_y[MAX_VERTICES];
   int     contour_len;
   bit     contour_dropped;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Squared distance from point q to segment a-b, rounded down, in squared coordinate units.
   function automatic logic [127:0] segment_dist_sq(longint ax, longint ay, longint bx,
                                                    longint by, longint qx, longint qy);
      longint dx, dy, px, py, dot;
      logic [127:0] pa2, pb2, len2, num, quo;
      dx = bx - ax;
      dy = by - ay;
      px = qx - ax;
      py = qy - ay;
      pa2 = 128'(px * px + py * py);
      pb2 = 128'((qx - bx) * (qx - bx) + (qy - by) * (qy - by));
      len2 = 128'(dx * dx + dy * dy);
      dot = px * dx + py * dy;
      // Degenerate segment or point behind the start: nearest is the start vertex.
      if (len2 == 0 || dot < 0) return pa2;
      // Past the end of the segment: nearest is the end vertex.
      if (128'(dot) > len2) return pb2;
      // Perpendicular foot: |PA|^2 - ceil(dot^2 / len^2) gives floor(cross^2 / len^2).
      num = 128'(dot) * 128'(dot);
      quo = num / len2;
      if (num % len2 != 0) quo = quo + 128'(1);
      return pa2 - quo;
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [127:0] value);
      logic [63:0] root, trial;
      root = '0;
      for (int b = 34; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (128'(trial) * 128'(trial) <= value) root = trial;
      end
      return root;
   endfunction

   // Apply one accepted request to the shadow contour; queue a response for queries.
   task automatic apply_request(request_type r);
      logic [127:0] best, d;
      logic [63:0]  root;
      answer_type   a;
      case (r.kind)
         pld_pkg::KIND_CLEAR: begin
            contour_len = 0;
            contour_dropped = 1'b0;
         end
         pld_pkg::KIND_APPEND: begin
            if (contour_len < MAX_VERTICES) begin
               contour_x[contour_len] = longint'(r.x);
               contour_y[contour_len] = longint'(r.y);
               contour_len++;
            end else begin
               contour_dropped = 1'b1;
            end
         end
         pld_pkg::KIND_QUERY: begin
            a.distance = r.prior;
            if (contour_len >= 2) begin
               best = segment_dist_sq(contour_x[0], contour_y[0], contour_x[1],
                                      contour_y[1], longint'(r.x), longint'(r.y));
               for (int j = 1; j + 1 < contour_len; j++) begin
                  d = segment_dist_sq(contour_x[j], contour_y[j], contour_x[j + 1],
                                      contour_y[j + 1], longint'(r.x), longint'(r.y));
                  if (d < best) best = d;
               end
               root = floor_sqrt(best);
               if (root < 64'(r.prior)) a.distance = root[pld_pkg::DIST_BITS-1:0];
            end
            a.truncated = contour_dropped;
            expected_answers.push_back(a);
         end
         default: ;  // unused kind: no state change, no response
      endcase
   endtask

   // Note acceptance at the rising edge and predict right away.
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) begin
         apply_request(current_request);
         request_fired = 1'b1;
      end
   end

   // Request driver: change inputs at the falling edge only.
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (req.valid && !request_fired) begin
         // hold the request until it is taken
      end else if (pending_requests.size() != 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
         current_request = pending_requests.pop_front();
         req.valid          <= 1'b1;
         req.kind           <= current_request.kind;
         req.point_x        <= current_request.x;
         req.point_y        <= current_request.y;
         req.prior_distance <= current_request.prior;
      end else begin
         req.valid <= 1'b0;
      end
      request_fired = 1'b0;
      rsp.ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   // Response monitor: compare against the oldest expectation.
   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_answers.size() == 0) begin
            $error("unexpected response: distance %0d", rsp.distance);
            mismatches++;
         end else begin
            e = expected_answers.pop_front();
            if (rsp.distance !== e.distance) begin
               $error("distance: expected %0d, got %0d", e.distance, rsp.distance);
               mismatches++;
            end
            if (rsp.contour_truncated !== e.truncated) begin
               $error("contour_truncated: expected %0d, got %0d", e.truncated,
                      rsp.contour_truncated);
               mismatches++;
            end
         end
      end
   end

   task automatic push_request(logic [pld_pkg::KIND_BITS-1:0] kind, int x, int y,
                               int prior);
      request_type r;
      r.kind  = kind;
      r.x     = x[COORD_BITS-1:0];
      r.y     = y[COORD_BITS-1:0];
      r.prior = prior[pld_pkg::DIST_BITS-1:0];
      pending_requests.push_back(r);
   endtask

   // Mix full-range values, extremes and a small window where segments stay short.
   function automatic int pick_coord();
      case ($urandom_range(3))
         0: return $signed($urandom_range(COORD_MAX, 0)) - ($urandom_range(1) ? (1 << 23) : 0);
         1: return $urandom_range(1) ? COORD_MIN : COORD_MAX;
         default: return int'($urandom_range(8000)) - 4000;
      endcase
   endfunction

   function automatic int pick_prior();
      case ($urandom_range(3))
         0: return DIST_MAX;
         1: return int'($urandom_range(2000));
         default: return int'($urandom());
      endcase
   endfunction

   // Fill a random phase: mostly well-formed contours followed by queries.
   task automatic push_random_phase(int count);
      int n, verts;
      n = 0;
      while (n < count) begin
         if ($urandom_range(9) < 7) begin
            push_request(pld_pkg::KIND_CLEAR, pick_coord(), pick_coord(), pick_prior());
            n++;
         end
         verts = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(8, 2);
         repeat (verts) begin
            push_request(pld_pkg::KIND_APPEND, pick_coord(), pick_coord(), pick_prior());
            n++;
         end
         repeat ($urandom_range(4, 1)) begin
            push_request(pld_pkg::KIND_QUERY, pick_coord(), pick_coord(), pick_prior());
            n++;
         end
         if ($urandom_range(19) == 0) begin
            push_request(KIND_UNUSED, pick_coord(), pick_coord(), pick_prior());
            n++;
         end
      end
   endtask

   // Wait until every request is taken and every response is back.
   task automatic drain();
      while (pending_requests.size() != 0 || req.valid || expected_answers.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      mismatches = 0;
      contour_len = 0;
      contour_dropped = 1'b0;
      request_fired = 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.kind = pld_pkg::KIND_CLEAR;
      req.point_x = '0;
      req.point_y = '0;
      req.prior_distance = '0;
      rsp.ready = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty and one-vertex contours pass the prior through.
      push_request(pld_pkg::KIND_QUERY, 0, 0, 12345);
      push_request(pld_pkg::KIND_APPEND, 100, 100, 0);
      push_request(pld_pkg::KIND_QUERY, 0, 0, DIST_MAX);
      // Degenerate segment: both vertices at the same spot.
      push_request(pld_pkg::KIND_APPEND, 100, 100, 0);
      push_request(pld_pkg::KIND_QUERY, 400, 500, DIST_MAX);
      // Extreme corners: a contour through corners of the range, queried at and near them.
      push_request(pld_pkg::KIND_CLEAR, 0, 0, 0);
      push_request(pld_pkg::KIND_APPEND, COORD_MIN, COORD_MIN, 0);
      push_request(pld_pkg::KIND_APPEND, COORD_MAX, COORD_MAX, 0);
      push_request(pld_pkg::KIND_APPEND, COORD_MAX, COORD_MIN, 0);
      push_request(pld_pkg::KIND_QUERY, COORD_MIN, COORD_MAX, DIST_MAX);
      push_request(pld_pkg::KIND_QUERY, COORD_MAX, COORD_MAX, DIST_MAX);
      push_request(pld_pkg::KIND_QUERY, 0, 300, DIST_MAX);
      push_request(pld_pkg::KIND_QUERY, 0, 300, 0);
      push_request(pld_pkg::KIND_QUERY, -1, 0, 7);
      push_request(KIND_UNUSED, 5, 5, 5);
      push_request(pld_pkg::KIND_QUERY, COORD_MAX, 0, DIST_MAX);
      push_request(pld_pkg::KIND_CLEAR, 0, 0, 0);
      push_request(pld_pkg::KIND_QUERY, 1, 1, 99);
      push_request(pld_pkg::KIND_APPEND, -50, 20, 0);
      push_request(pld_pkg::KIND_APPEND, 60, -20, 0);
      push_request(pld_pkg::KIND_QUERY, 0, 0, DIST_MAX);
      drain();

      // Random phases under different idle patterns; drain between them.
      send_idle_pct = 0;  stall_pct = 0;  push_random_phase(139); drain();
      send_idle_pct = 79; stall_pct = 0;  push_random_phase(139); drain();
      send_idle_pct = 0;  stall_pct = 79; push_random_phase(139); drain();
      send_idle_pct = 7;  stall_pct = 7;  push_random_phase(139); drain();
      repeat (200) @(posedge clock);

      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog: allow for long queries and heavy stalling.
   initial begin
      #40000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- sim.f -----
src/pld_pkg.sv
src/pld_req_if.sv
src/pld_rsp_if.sv
src/pld_vertex_mem.sv
src/pld_seg_dist.sv
src/pld_isqrt.sv
src/point_to_polyline_distance_unit.sv
bench/point_to_polyline_distance_unit_test.sv
